@@ sv/kms_pkg.sv @@
// Shared types, constants and codes for the keypad matrix scanner.
package kms_pkg;

    localparam int ROWS_DEF     = 6;
    localparam int COLS_DEF     = 16;
    localparam int MAX_KEYS_DEF = 64;

    localparam int CNT_W  = 7;
    localparam int CODE_W = 8;

    localparam logic [15:0] POLL_DELAY_RST   = 16'd30;
    localparam logic [6:0]  REPORT_LIMIT_RST = 7'd64;

    localparam logic REG_POLL_DELAY   = 1'b0;
    localparam logic REG_REPORT_LIMIT = 1'b1;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_EDGE   = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SCAN = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_ERR  = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] column_bits;
    } in_item_t;

    typedef struct packed {
        logic [5:0] row_drive;
        logic [7:0] key_code;
        logic       code_valid;
        logic       last_of_run;
        logic [6:0] key_count;
        logic       report_flag;
        logic       error_flag;
        logic [1:0] mode_now;
    } out_item_t;

    typedef enum logic [3:0] {
        CMD_NONE   = 4'b0001,
        CMD_TICK   = 4'b0010,
        CMD_EDGE   = 4'b0100,
        CMD_SAMPLE = 4'b1000
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] column_bits;
    } cmd_t;

endpackage

@@ sv/kms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/kms_front.sv @@
// Front end: accepts input requests, classifies the opcode, queues commands.
module kms_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  kms_pkg::in_item_t item,
    output logic             cmd_valid,
    input  logic             cmd_pop,
    output kms_pkg::cmd_t    cmd
);
    kms_pkg::cmd_t q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    kms_pkg::cmd_t in_cmd;
    logic do_push, do_pop;

    // classify the opcode
    always_comb
    begin
        in_cmd.column_bits = item.column_bits;
        case (item.opcode)
            kms_pkg::OP_TICK:   in_cmd.kind = kms_pkg::CMD_TICK;
            kms_pkg::OP_EDGE:   in_cmd.kind = kms_pkg::CMD_EDGE;
            kms_pkg::OP_SAMPLE: in_cmd.kind = kms_pkg::CMD_SAMPLE;
            default:            in_cmd.kind = kms_pkg::CMD_NONE;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    // advance pointers
    always_comb
    begin
        wp_next  = wp_reg ^ do_push;
        rp_next  = rp_reg ^ do_pop;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // hold queued commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= in_cmd;
        end
    end
endmodule

@@ sv/kms_back.sv @@
// Back end: scan sequencer, code lists in RAM, compare/copy walk, result queue.
module kms_back #(
    parameter int ROWS     = kms_pkg::ROWS_DEF,
    parameter int COLS     = kms_pkg::COLS_DEF,
    parameter int MAX_KEYS = kms_pkg::MAX_KEYS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    input  kms_pkg::cmd_t     cmd,
    input  logic [15:0]       poll_delay,
    input  logic [6:0]        report_limit,
    output logic              empty,
    input  logic              pop,
    output kms_pkg::out_item_t result
);
    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam logic [6:0] MAXK = 7'(MAX_KEYS);
    localparam logic [2:0] LAST_ROW = 3'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
    localparam logic [7:0] IDLE_DRIVE = 8'((1 << ROWS) - 1);

    typedef enum logic [6:0] {
        ST_CMD   = 7'b0000001,
        ST_COL   = 7'b0000010,
        ST_CMPRD = 7'b0000100,
        ST_CMPCK = 7'b0001000,
        ST_CPRD  = 7'b0010000,
        ST_CPWR  = 7'b0100000,
        ST_STAT  = 7'b1000000
    } st_t;

    st_t          st_reg, st_next;
    logic [1:0]   ph_reg, ph_next;
    logic [2:0]   row_reg, row_next;
    logic [15:0]  wc_reg, wc_next;
    logic [6:0]   fc_reg, fc_next;
    logic [6:0]   kc_reg, kc_next;
    logic [6:0]   k_reg, k_next;
    logic [CW-1:0] cj_reg, cj_next;
    logic [15:0]  cols_reg, cols_next;
    logic         rep_reg, rep_next;

    logic [6:0]   limit;
    logic         f_we, k_we;
    logic [7:0]   f_wdata, f_rdata, k_rdata, code;

    // result queue
    kms_pkg::out_item_t oq_reg [2];
    logic       owp_reg, orp_reg;
    logic [1:0] ocnt_reg;
    logic       o_push, o_pop, room;
    kms_pkg::out_item_t o_item;
    logic [7:0] drive;

    assign limit = (report_limit < MAXK) ? report_limit : MAXK;
    assign code  = {row_reg + 4'd1, 4'd0} | {3'd0, 5'(cj_reg) + 5'd1};
    assign room  = (ocnt_reg != 2'd2);

    kms_ram #(.WIDTH(8), .DEPTH(MAX_KEYS)) u_frame (
        .clk(clk), .we(f_we), .waddr(fc_reg[AW-1:0]), .wdata(f_wdata),
        .raddr(k_reg[AW-1:0]), .rdata(f_rdata)
    );
    kms_ram #(.WIDTH(8), .DEPTH(MAX_KEYS)) u_kept (
        .clk(clk), .we(k_we), .waddr(k_reg[AW-1:0]), .wdata(f_rdata),
        .raddr(k_reg[AW-1:0]), .rdata(k_rdata)
    );

    // row drive from the registered phase
    always_comb
    begin
        case (ph_reg)
            kms_pkg::PH_IDLE: drive = IDLE_DRIVE;
            kms_pkg::PH_SCAN: drive = 8'd1 << row_reg;
            default:          drive = 8'd0;
        endcase
    end

    // sequencer
    always_comb
    begin
        st_next   = st_reg;
        ph_next   = ph_reg;
        row_next  = row_reg;
        wc_next   = wc_reg;
        fc_next   = fc_reg;
        kc_next   = kc_reg;
        k_next    = k_reg;
        cj_next   = cj_reg;
        cols_next = cols_reg;
        rep_next  = rep_reg;
        cmd_pop   = 1'b0;
        f_we      = 1'b0;
        f_wdata   = code;
        k_we      = 1'b0;
        o_push    = 1'b0;
        o_item.row_drive   = drive[5:0];
        o_item.key_code    = 8'd0;
        o_item.code_valid  = 1'b0;
        o_item.last_of_run = 1'b1;
        o_item.key_count   = kc_reg;
        o_item.report_flag = rep_reg;
        o_item.error_flag  = (ph_reg == kms_pkg::PH_ERR);
        o_item.mode_now    = ph_reg;
        case (st_reg)
            ST_CMD:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    rep_next = 1'b0;
                    st_next  = ST_STAT;
                    if (ph_reg == kms_pkg::PH_IDLE && cmd.kind == kms_pkg::CMD_EDGE)
                    begin
                        ph_next  = kms_pkg::PH_SCAN;
                        row_next = 3'd0;
                        fc_next  = 7'd0;
                    end
                    else if (ph_reg == kms_pkg::PH_WAIT &&
                             cmd.kind == kms_pkg::CMD_TICK)
                    begin
                        if (wc_reg <= 16'd1)
                        begin
                            ph_next  = kms_pkg::PH_SCAN;
                            row_next = 3'd0;
                            fc_next  = 7'd0;
                        end
                        else
                        begin
                            wc_next = wc_reg - 16'd1;
                        end
                    end
                    else if (ph_reg == kms_pkg::PH_SCAN &&
                             cmd.kind == kms_pkg::CMD_SAMPLE)
                    begin
                        cols_next = cmd.column_bits;
                        cj_next   = '0;
                        st_next   = ST_COL;
                    end
                end
            end
            ST_COL:
            begin
                // one column per cycle
                if (cols_reg[cj_reg] && fc_reg >= limit)
                begin
                    ph_next = kms_pkg::PH_ERR;
                    st_next = ST_STAT;
                end
                else
                begin
                    if (cols_reg[cj_reg])
                    begin
                        f_we    = 1'b1;
                        fc_next = fc_reg + 7'd1;
                    end
                    if (cj_reg == LAST_COL)
                    begin
                        if (row_reg != LAST_ROW)
                        begin
                            row_next = row_reg + 3'd1;
                            st_next  = ST_STAT;
                        end
                        else
                        begin
                            k_next  = 7'd0;
                            st_next = ST_CMPRD;
                        end
                    end
                    else
                    begin
                        cj_next = cj_reg + CW'(1);
                    end
                end
            end
            ST_CMPRD:
            begin
                if (fc_reg != kc_reg)
                begin
                    // list changed: keep and report it
                    kc_next  = fc_reg;
                    k_next   = 7'd0;
                    rep_next = 1'b1;
                    if (fc_reg == 7'd0)
                    begin
                        ph_next  = kms_pkg::PH_IDLE;
                        row_next = 3'd0;
                        st_next  = ST_STAT;
                    end
                    else
                    begin
                        ph_next  = kms_pkg::PH_SCAN;
                        row_next = 3'd0;
                        st_next  = ST_CPRD;
                    end
                end
                else if (k_reg == fc_reg)
                begin
                    // unchanged list
                    st_next = ST_STAT;
                    if (poll_delay == 16'd0)
                    begin
                        ph_next  = kms_pkg::PH_SCAN;
                        row_next = 3'd0;
                        fc_next  = 7'd0;
                    end
                    else
                    begin
                        ph_next = kms_pkg::PH_WAIT;
                        wc_next = poll_delay;
                    end
                end
                else
                begin
                    st_next = ST_CMPCK;
                end
            end
            ST_CMPCK:
            begin
                if (f_rdata != k_rdata)
                begin
                    kc_next  = fc_reg;
                    k_next   = 7'd0;
                    rep_next = 1'b1;
                    ph_next  = kms_pkg::PH_SCAN;
                    row_next = 3'd0;
                    st_next  = ST_CPRD;
                end
                else
                begin
                    k_next  = k_reg + 7'd1;
                    st_next = ST_CMPRD;
                end
            end
            ST_CPRD:
            begin
                st_next = ST_CPWR;
            end
            ST_CPWR:
            begin
                o_item.key_code    = f_rdata;
                o_item.code_valid  = 1'b1;
                o_item.last_of_run = (k_reg + 7'd1 == kc_reg);
                if (room)
                begin
                    k_we   = 1'b1;
                    o_push = 1'b1;
                    k_next = k_reg + 7'd1;
                    if (k_reg + 7'd1 == kc_reg)
                    begin
                        fc_next = 7'd0;
                        st_next = ST_CMD;
                    end
                    else
                    begin
                        st_next = ST_CPRD;
                    end
                end
            end
            ST_STAT:
            begin
                if (room)
                begin
                    o_push  = 1'b1;
                    st_next = ST_CMD;
                end
            end
            default:
            begin
                st_next = ST_CMD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_CMD;
            ph_reg  <= kms_pkg::PH_IDLE;
            row_reg <= 3'd0;
            wc_reg  <= 16'd0;
            fc_reg  <= 7'd0;
            kc_reg  <= 7'd0;
            k_reg   <= 7'd0;
            cj_reg  <= '0;
            rep_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            ph_reg  <= ph_next;
            row_reg <= row_next;
            wc_reg  <= wc_next;
            fc_reg  <= fc_next;
            kc_reg  <= kc_next;
            k_reg   <= k_next;
            cj_reg  <= cj_next;
            rep_reg <= rep_next;
        end
    end

    // hold sampled columns
    always_ff @(posedge clk)
    begin
        cols_reg <= cols_next;
    end

    // result queue control
    assign empty  = (ocnt_reg == 2'd0);
    assign o_pop  = pop && !empty;
    assign result = oq_reg[orp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owp_reg  <= 1'b0;
            orp_reg  <= 1'b0;
            ocnt_reg <= 2'd0;
        end
        else
        begin
            owp_reg  <= owp_reg ^ o_push;
            orp_reg  <= orp_reg ^ o_pop;
            ocnt_reg <= ocnt_reg + {1'b0, o_push} - {1'b0, o_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_push)
        begin
            oq_reg[owp_reg] <= o_item;
        end
    end
endmodule

@@ sv/keypad_matrix_scanner.sv @@
// A status request passes through the command queue, ST_CMD and ST_STAT; a column
// sample also walks the columns, and a final-row sample adds a compare walk over the
// code lists and a copy step per reported code. The sequencer takes a new request
// only when done with the last, scans one column per cycle, and stalls on a full result queue.
// Reset: async active low; block idle, rows all driven, queues empty,
// registers back to poll_delay 30 and report_limit 64.
module keypad_matrix_scanner #(
    parameter int ROWS     = kms_pkg::ROWS_DEF,
    parameter int COLS     = kms_pkg::COLS_DEF,
    parameter int MAX_KEYS = kms_pkg::MAX_KEYS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  kms_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output kms_pkg::out_item_t result,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [15:0]        cfg_wdata
);
    logic [15:0] poll_delay_reg;
    logic [6:0]  report_limit_reg;
    logic        cmd_valid, cmd_pop;
    kms_pkg::cmd_t cmd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_delay_reg   <= kms_pkg::POLL_DELAY_RST;
            report_limit_reg <= kms_pkg::REPORT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == kms_pkg::REG_POLL_DELAY)
            begin
                poll_delay_reg <= cfg_wdata;
            end
            else
            begin
                report_limit_reg <= cfg_wdata[6:0];
            end
        end
    end

    kms_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
    );

    kms_back #(.ROWS(ROWS), .COLS(COLS), .MAX_KEYS(MAX_KEYS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
        .cmd(cmd), .poll_delay(poll_delay_reg), .report_limit(report_limit_reg),
        .empty(empty), .pop(pop), .result(result)
    );
endmodule

@@ sv/kms_checker.sv @@
// Port-level checks on the scanner's results, bound to the top level.
module kms_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input kms_pkg::out_item_t result
);
    // a reported key always belongs to a change report
    a_valid_report: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.code_valid) |-> result.report_flag)
        else $error("key code outside a report");

    // a status result closes its request
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.code_valid) |-> result.last_of_run)
        else $error("status result not marked last");

    // error flag tracks error mode
    a_err_mode: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.error_flag == (result.mode_now == kms_pkg::PH_ERR)))
        else $error("error flag and mode disagree");

    // a reported key implies a nonempty list
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.code_valid) |-> (result.key_count != 7'd0))
        else $error("key reported with zero count");
endmodule

bind keypad_matrix_scanner kms_checker u_kms_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .result(result)
);
